/* src/wsc_pkg.sv */
// ----------------------------------------------------------------------------
// Weather channel scan controller package
// Shared codes, state types and the channel frequency table.
// ----------------------------------------------------------------------------
`default_nettype none

package wsc_pkg;

	// Number of channels in the frequency table.
	localparam int NUM_CHANNELS_DEF = 10;

	// Scan timing and confirmation constants.
	localparam logic [1:0] HIT_CONFIRM  = 2'd3;
	localparam logic [7:0] CARRIER_HOLD = 8'd50;
	localparam logic [7:0] STEP_DWELL   = 8'd2;
	localparam logic [7:0] START_DWELL  = 8'd4;

	// Reset values of the configuration registers.
	localparam logic [7:0] LOST_DWELL_RST = 8'd30;
	localparam logic [7:0] FIND_DWELL_RST = 8'd30;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SCAN_MODE  = 2'd0;
	localparam logic [1:0] CFG_LOST_DWELL = 2'd1;
	localparam logic [1:0] CFG_FIND_DWELL = 2'd2;

	// Scan modes.
	localparam logic [1:0] SM_TIME    = 2'd0;
	localparam logic [1:0] SM_CARRIER = 2'd1;
	localparam logic [1:0] SM_FIND    = 2'd2;

	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_POLL  = 3'd1,
		OP_UP    = 3'd2,
		OP_DOWN  = 3'd3,
		OP_SCAN  = 3'd4,
		OP_ENTER = 3'd5,
		OP_EXIT  = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		PH_IDLE        = 3'd0,
		PH_SCANNING    = 3'd1,
		PH_WAIT_TIME   = 3'd2,
		PH_WAIT_LOST   = 3'd3,
		PH_WAIT_RECALL = 3'd4,
		PH_STOP        = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		BP_NONE  = 3'd0,
		BP_STEP  = 3'd1,
		BP_START = 3'd2,
		BP_STOP  = 3'd3,
		BP_ENTER = 3'd4,
		BP_EXIT  = 3'd5
	} beep_t;

	typedef struct packed {
		logic [3:0] chan;
		phase_t     phase;
		logic [7:0] dwell;
		logic [1:0] hits;
		logic       scan_up;
		logic       in_mode;
	} wsc_state_t;

	typedef struct packed {
		logic [1:0] scan_mode;
		logic [7:0] lost_dwell;
		logic [7:0] find_dwell;
	} wsc_cfg_t;

	typedef struct packed {
		logic  retune;
		beep_t beep;
	} wsc_event_t;

	// Channel frequency in 10 Hz units; entries past the table read as the top one.
	function automatic logic [23:0] chan_freq(input logic [3:0] chan);
		logic [23:0] f;
		unique case (chan)
			4'd0:    f = 24'd16255000;
			4'd1:    f = 24'd16240000;
			4'd2:    f = 24'd16247500;
			4'd3:    f = 24'd16242500;
			4'd4:    f = 24'd16245000;
			4'd5:    f = 24'd16250000;
			4'd6:    f = 24'd16252500;
			4'd7:    f = 24'd16165000;
			4'd8:    f = 24'd16177500;
			default: f = 24'd16327500;
		endcase
		return f;
	endfunction

endpackage

`default_nettype wire

/* src/weather_channel_scan_controller.sv */
// ----------------------------------------------------------------------------
// Weather channel scan controller
// Scan state machine over the fixed weather receive channels.
// ----------------------------------------------------------------------------
//
// Channel   Handshake               Payload
// input     in_valid / in_stall     operation, squelch_open
// result    out_valid / out_stall   channel, frequency, scan_phase,
//                                   mode_active, retune, beep_code
// config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Each request is accepted into the input register, where the next-state
// logic works on it, and moves on into the result register once that
// register is empty or being drained.
// A new request is accepted every cycle while results are taken; the input
// register lets one request in while a finished result still waits.
// Reset returns the controller to channel 0, idle, outside weather mode.
// The configuration port never stalls.
//
`default_nettype none

module weather_channel_scan_controller import wsc_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,

	input  wire        in_valid,
	output logic       in_stall,
	input  wire [2:0]  operation,
	input  wire        squelch_open,

	output logic       out_valid,
	input  wire        out_stall,
	output logic [3:0] channel,
	output logic [23:0] frequency,
	output logic [2:0] scan_phase,
	output logic       mode_active,
	output logic       retune,
	output logic [2:0] beep_code,

	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire [1:0]  cfg_index,
	input  wire [7:0]  cfg_data
);

	// Configuration registers. A write to an index past the list is dropped.
	wsc_cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scan_mode <= SM_TIME;
			cfg_q.lost_dwell <= LOST_DWELL_RST;
			cfg_q.find_dwell <= FIND_DWELL_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_SCAN_MODE) begin
				cfg_q.scan_mode <= cfg_data[1:0];
			end else if (cfg_index == CFG_LOST_DWELL) begin
				cfg_q.lost_dwell <= cfg_data;
			end else if (cfg_index == CFG_FIND_DWELL) begin
				cfg_q.find_dwell <= cfg_data;
			end
		end
	end

	// Flow control. The result register loads when it is empty or being
	// drained; the input register then hands its request on and refills.
	logic       valid_s1;
	logic [2:0] op_s1;
	logic       sq_s1;
	logic       out_load;
	logic       advance;

	assign out_load = !out_valid || !out_stall;
	assign advance  = valid_s1 && out_load;
	assign in_stall = valid_s1 && !out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1 <= operation;
			sq_s1 <= squelch_open;
		end
	end

	// Controller state, updated once for every request that moves into
	// the result register.
	wsc_state_t state_q;
	wsc_state_t state_nxt;
	wsc_event_t evt;

	wsc_next #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_next (
		.cur(state_q),
		.cfg(cfg_q),
		.operation(op_s1),
		.squelch_open(sq_s1),
		.nxt(state_nxt),
		.evt(evt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.chan <= 4'd0;
			state_q.phase <= PH_IDLE;
			state_q.dwell <= 8'd0;
			state_q.hits <= 2'd0;
			state_q.scan_up <= 1'b1;
			state_q.in_mode <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register. Each result reports the state after its request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			channel <= state_nxt.chan;
			frequency <= chan_freq(state_nxt.chan);
			scan_phase <= state_nxt.phase;
			mode_active <= state_nxt.in_mode;
			retune <= evt.retune;
			beep_code <= evt.beep;
		end
	end

	// The channel index never leaves the configured range.
	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, channel} < 5'(NUM_CHANNELS)))
		else $error("channel index out of range");

	// Entering weather mode always retunes and reports the mode as active.
	a_enter_retune: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && beep_code == BP_ENTER) |-> (retune && mode_active))
		else $error("enter without retune or mode");

	// Every step beep comes with a new channel to tune.
	a_step_retune: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && beep_code == BP_STEP) |-> retune)
		else $error("step beep without retune");

	// Outside weather mode nothing retunes the receiver.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !mode_active) |-> !retune)
		else $error("retune outside weather mode");

endmodule

`default_nettype wire

/* src/wsc_next.sv */
// ----------------------------------------------------------------------------
// Weather channel scan next-state logic
// Applies one request to the controller state and reports the events.
// ----------------------------------------------------------------------------
`default_nettype none

module wsc_next import wsc_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  wire wsc_state_t cur,
	input  wire wsc_cfg_t   cfg,
	input  wire [2:0]       operation,
	input  wire             squelch_open,
	output wsc_state_t      nxt,
	output wsc_event_t      evt
);

	localparam logic [3:0] LAST_CHAN = 4'(NUM_CHANNELS - 1);
	localparam logic [4:0] NUM_CHAN5 = 5'(NUM_CHANNELS);

	function automatic logic [3:0] chan_up(input logic [3:0] c);
		return ({1'b0, c} + 5'd1 >= NUM_CHAN5) ? 4'd0 : c + 4'd1;
	endfunction

	function automatic logic [3:0] chan_down(input logic [3:0] c);
		return (c != 4'd0 && {1'b0, c} < NUM_CHAN5) ? c - 4'd1 : LAST_CHAN;
	endfunction

	always_comb begin
		nxt = cur;
		evt.retune = 1'b0;
		evt.beep = BP_NONE;

		unique case (op_t'(operation))
			OP_TICK: begin
				if (cur.dwell != 8'd0) begin
					nxt.dwell = cur.dwell - 8'd1;
				end
			end
			OP_ENTER: begin
				if ({1'b0, cur.chan} >= NUM_CHAN5) begin
					nxt.chan = 4'd0;
				end
				nxt.in_mode = 1'b1;
				evt.retune = 1'b1;
				evt.beep = BP_ENTER;
			end
			OP_EXIT: begin
				if (cur.in_mode) begin
					nxt.in_mode = 1'b0;
					evt.beep = BP_EXIT;
				end
			end
			OP_POLL: begin
				if (cur.in_mode) begin
					unique case (cur.phase)
						PH_SCANNING: begin
							if (squelch_open) begin
								if (cur.hits < HIT_CONFIRM) begin
									nxt.hits = cur.hits + 2'd1;
								end else if (cfg.scan_mode == SM_TIME) begin
									nxt.phase = PH_WAIT_TIME;
									nxt.dwell = cfg.lost_dwell;
								end else if (cfg.scan_mode == SM_CARRIER) begin
									nxt.phase = PH_WAIT_LOST;
									nxt.dwell = cfg.lost_dwell;
								end else if (cfg.scan_mode == SM_FIND) begin
									nxt.phase = PH_STOP;
									nxt.dwell = cfg.find_dwell;
								end
							end else begin
								if (cur.dwell == 8'd0) begin
									nxt.chan = cur.scan_up ? chan_up(cur.chan)
										: chan_down(cur.chan);
									nxt.phase = PH_SCANNING;
									nxt.dwell = STEP_DWELL;
									evt.retune = 1'b1;
								end
								nxt.hits = 2'd0;
							end
						end
						PH_WAIT_TIME: begin
							// A carrier in carrier mode reloads the hold before the step check.
							if (cfg.scan_mode == SM_CARRIER && squelch_open) begin
								nxt.dwell = CARRIER_HOLD;
							end
							if (nxt.dwell == 8'd0) begin
								nxt.chan = cur.scan_up ? chan_up(cur.chan)
									: chan_down(cur.chan);
								nxt.phase = PH_SCANNING;
								nxt.dwell = STEP_DWELL;
								evt.retune = 1'b1;
							end
							nxt.hits = 2'd0;
						end
						PH_WAIT_LOST: begin
							if (!squelch_open) begin
								if (cur.dwell == 8'd0) begin
									nxt.phase = PH_WAIT_RECALL;
								end
							end else begin
								nxt.dwell = cfg.lost_dwell;
							end
						end
						PH_WAIT_RECALL: begin
							if (cur.dwell == 8'd0) begin
								nxt.chan = cur.scan_up ? chan_up(cur.chan)
									: chan_down(cur.chan);
								nxt.phase = PH_SCANNING;
								nxt.dwell = STEP_DWELL;
								evt.retune = 1'b1;
							end
							nxt.hits = 2'd0;
						end
						PH_STOP: begin
							nxt.phase = PH_IDLE;
							nxt.dwell = 8'd0;
							nxt.hits = 2'd0;
							evt.retune = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			OP_UP, OP_DOWN: begin
				if (cur.in_mode) begin
					evt.beep = BP_STEP;
					evt.retune = 1'b1;
					if (cur.phase == PH_IDLE) begin
						nxt.chan = (operation == OP_UP) ? chan_up(cur.chan)
							: chan_down(cur.chan);
					end else begin
						// A step is taken at once, whatever the dwell, so a step always follows.
						nxt.scan_up = (operation == OP_UP);
						nxt.chan = (operation == OP_UP) ? chan_up(cur.chan)
							: chan_down(cur.chan);
						nxt.phase = PH_SCANNING;
						nxt.dwell = STEP_DWELL;
					end
				end
			end
			OP_SCAN: begin
				if (cur.in_mode) begin
					if (cur.phase == PH_IDLE) begin
						nxt.phase = PH_SCANNING;
						nxt.dwell = START_DWELL;
						nxt.scan_up = 1'b1;
						evt.beep = BP_START;
					end else begin
						nxt.phase = PH_IDLE;
						nxt.dwell = 8'd0;
						evt.retune = 1'b1;
						evt.beep = BP_STOP;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

/* sim/tb_weather_channel_scan_controller.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Weather channel scan controller testbench
// Drives operation requests with random gaps and output stalls, mirrors the
// scan state machine in a scoreboard and checks every response field by field.
// ----------------------------------------------------------------------------

module tb_weather_channel_scan_controller;
	import wsc_pkg::*;

	localparam int          CHAN_COUNT      = NUM_CHANNELS_DEF;
	localparam logic [1:0]  HITS_TO_CONFIRM = 2'd3;
	localparam logic [7:0]  HOLD_CARRIER    = 8'd50;
	localparam logic [7:0]  DWELL_STEP      = 8'd2;
	localparam logic [7:0]  DWELL_START     = 8'd4;
	localparam logic [7:0]  DWELL_RESET     = 8'd30;
	localparam int unsigned PHASE_REQUESTS  = 265;

	// Channel frequencies in 10 Hz units. Indexes past the ten real channels
	// report the top frequency.
	localparam logic [23:0] CHANNEL_FREQ [16] = '{
		24'd16255000, 24'd16240000, 24'd16247500, 24'd16242500,
		24'd16245000, 24'd16250000, 24'd16252500, 24'd16165000,
		24'd16177500, 24'd16327500, 24'd16327500, 24'd16327500,
		24'd16327500, 24'd16327500, 24'd16327500, 24'd16327500
	};

	typedef struct {
		logic [3:0]  chan;
		logic [23:0] freq;
		logic [2:0]  phase;
		logic        mode;
		logic        retune;
		logic [2:0]  beep;
	} scan_response_t;

	// The scoreboard keeps its own copy of the controller state and registers.
	// Every accepted request advances that copy and queues the response it
	// should produce; responses leave the block in request order.
	class scan_scoreboard;
		logic [1:0]     scan_mode;
		logic [7:0]     lost_dwell;
		logic [7:0]     find_dwell;
		logic [3:0]     chan;
		phase_t         phase;
		logic [7:0]     dwell;
		logic [1:0]     hits;
		logic           scan_up;
		logic           in_mode;
		logic           retune_now;
		beep_t          beep_now;
		scan_response_t awaited_q[$];
		int unsigned    err_count;
		int unsigned    seen_count;

		function new();
			scan_mode  = SM_TIME;
			lost_dwell = DWELL_RESET;
			find_dwell = DWELL_RESET;
			chan       = '0;
			phase      = PH_IDLE;
			dwell      = '0;
			hits       = '0;
			scan_up    = 1'b1;
			in_mode    = 1'b0;
			err_count  = 0;
			seen_count = 0;
		endfunction

		task report_mismatch(input string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			err_count++;
		endtask

		function void write_reg(input logic [1:0] idx, input logic [7:0] val);
			case (idx)
				CFG_SCAN_MODE:  scan_mode  = val[1:0];
				CFG_LOST_DWELL: lost_dwell = val;
				CFG_FIND_DWELL: find_dwell = val;
				default: ;
			endcase
		endfunction

		function int unsigned pending();
			return awaited_q.size();
		endfunction

		function void step_channel(input logic up);
			if (up) begin
				chan = (chan + 1 >= CHAN_COUNT) ? 4'd0 : chan + 4'd1;
			end else begin
				chan = (chan > 0 && chan < CHAN_COUNT) ? chan - 4'd1 : 4'(CHAN_COUNT - 1);
			end
			retune_now = 1'b1;
		endfunction

		// The scan only moves on once the dwell has run out.
		function void advance_scan();
			if (dwell == 0) begin
				step_channel(scan_up);
				phase = PH_SCANNING;
				dwell = DWELL_STEP;
			end
		endfunction

		function void poll_squelch(input logic sq);
			case (phase)
				PH_SCANNING: begin
					if (sq) begin
						if (hits < HITS_TO_CONFIRM) begin
							hits = hits + 2'd1;
						end else begin
							case (scan_mode)
								SM_TIME: begin
									phase = PH_WAIT_TIME;
									dwell = lost_dwell;
								end
								SM_CARRIER: begin
									phase = PH_WAIT_LOST;
									dwell = lost_dwell;
								end
								SM_FIND: begin
									phase = PH_STOP;
									dwell = find_dwell;
								end
								default: ;
							endcase
						end
					end else begin
						advance_scan();
						hits = '0;
					end
				end
				PH_WAIT_TIME: begin
					if (scan_mode == SM_CARRIER && sq)
						dwell = HOLD_CARRIER;
					advance_scan();
					hits = '0;
				end
				PH_WAIT_LOST: begin
					if (!sq) begin
						if (dwell == 0)
							phase = PH_WAIT_RECALL;
					end else begin
						dwell = lost_dwell;
					end
				end
				PH_WAIT_RECALL: begin
					advance_scan();
					hits = '0;
				end
				PH_STOP: begin
					phase      = PH_IDLE;
					dwell      = '0;
					retune_now = 1'b1;
					hits       = '0;
				end
				default: ;
			endcase
		endfunction

		function void step_key(input logic up);
			beep_now = BP_STEP;
			if (phase == PH_IDLE) begin
				step_channel(up);
			end else begin
				scan_up = up;
				dwell   = '0;
				advance_scan();
			end
		endfunction

		function void note_request(input logic [2:0] op, input logic sq);
			scan_response_t rsp;
			retune_now = 1'b0;
			beep_now   = BP_NONE;
			case (op)
				OP_TICK: begin
					if (dwell != 0)
						dwell = dwell - 8'd1;
				end
				OP_ENTER: begin
					if (chan >= CHAN_COUNT)
						chan = '0;
					in_mode    = 1'b1;
					retune_now = 1'b1;
					beep_now   = BP_ENTER;
				end
				OP_EXIT: begin
					if (in_mode) begin
						in_mode  = 1'b0;
						beep_now = BP_EXIT;
					end
				end
				OP_POLL: if (in_mode) poll_squelch(sq);
				OP_UP:   if (in_mode) step_key(1'b1);
				OP_DOWN: if (in_mode) step_key(1'b0);
				OP_SCAN: begin
					if (in_mode) begin
						if (phase == PH_IDLE) begin
							phase    = PH_SCANNING;
							dwell    = DWELL_START;
							scan_up  = 1'b1;
							beep_now = BP_START;
						end else begin
							phase      = PH_IDLE;
							dwell      = '0;
							retune_now = 1'b1;
							beep_now   = BP_STOP;
						end
					end
				end
				default: ;
			endcase
			rsp.chan   = chan;
			rsp.freq   = CHANNEL_FREQ[chan];
			rsp.phase  = phase;
			rsp.mode   = in_mode;
			rsp.retune = retune_now;
			rsp.beep   = beep_now;
			awaited_q.push_back(rsp);
		endfunction

		task compare_field(input string name, input logic [23:0] got, input logic [23:0] want);
			if (got !== want)
				report_mismatch($sformatf("response %0d %s got %0h want %0h",
					seen_count, name, got, want));
		endtask

		task check_response(input scan_response_t got);
			scan_response_t want;
			if (awaited_q.size() == 0) begin
				report_mismatch($sformatf("response %0d arrived with none outstanding",
					seen_count));
			end else begin
				want = awaited_q.pop_front();
				compare_field("channel", got.chan, want.chan);
				compare_field("frequency", got.freq, want.freq);
				compare_field("scan_phase", got.phase, want.phase);
				compare_field("mode_active", got.mode, want.mode);
				compare_field("retune", got.retune, want.retune);
				compare_field("beep_code", got.beep, want.beep);
			end
			seen_count++;
		endtask

		task flag_leftovers();
			if (awaited_q.size() != 0)
				report_mismatch($sformatf("%0d responses never arrived", awaited_q.size()));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  operation;
	logic        squelch_open;
	logic        out_valid;
	logic        out_stall;
	logic [3:0]  channel;
	logic [23:0] frequency;
	logic [2:0]  scan_phase;
	logic        mode_active;
	logic        retune;
	logic [2:0]  beep_code;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;

	scan_scoreboard sb;
	int unsigned    counted_requests;
	logic           quiet_in;
	logic           quiet_out;
	int unsigned    stall_left;

	weather_channel_scan_controller DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.squelch_open (squelch_open),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.channel      (channel),
		.frequency    (frequency),
		.scan_phase   (scan_phase),
		.mode_active  (mode_active),
		.retune       (retune),
		.beep_code    (beep_code),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the handshakes lock up. A correct run with every
	// request hit by the longest gap and the longest stall stays well inside.
	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Idle lengths for both sides: usually none, often a few cycles, now and
	// then a long pause.
	function automatic int unsigned draw_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(5, 40);
	endfunction

	// Response side back-pressure. Stalls change only on the falling edge,
	// and quiet stretches let responses drain at full rate for a while.
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0)
			quiet_out = ~quiet_out;
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else begin
			out_stall <= 1'b0;
			stall_left = quiet_out ? 0 : draw_gap();
		end
	end

	// Both handshakes are observed at the rising edge, before the block's own
	// registers update, so what is sampled is what the block saw.
	always @(posedge clk) begin
		scan_response_t got;
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_request(operation, squelch_open);
			if (out_valid && !out_stall) begin
				got.chan   = channel;
				got.freq   = frequency;
				got.phase  = scan_phase;
				got.mode   = mode_active;
				got.retune = retune;
				got.beep   = beep_code;
				sb.check_response(got);
			end
		end
	end

	// Presents one request after an optional gap and holds it until the
	// block takes it. Requests that the block only ignores are not counted
	// toward the random budget.
	task automatic send_request(input logic [2:0] op, input logic sq);
		int unsigned gap;
		logic        counts;
		if ($urandom_range(0, 49) == 0)
			quiet_in = ~quiet_in;
		gap = quiet_in ? 0 : draw_gap();
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
			operation <= 3'($urandom_range(0, 7));
			squelch_open <= 1'($urandom_range(0, 1));
		end
		case (op)
			OP_TICK, OP_ENTER: counts = 1'b1;
			OP_POLL, OP_UP, OP_DOWN, OP_SCAN, OP_EXIT: counts = sb.in_mode;
			default: counts = 1'b0;
		endcase
		@(negedge clk);
		in_valid     <= 1'b1;
		operation    <= op;
		squelch_open <= sq;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (counts)
			counted_requests++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Registers are only written once every response is back and the input
	// side has gone quiet, so no request in flight sees a half-changed setup.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4)
			@(negedge clk);
	endtask

	task automatic run_directed();
		// Everything but enter and tick is ignored outside weather mode,
		// including an exit, and the unused operation code always is.
		send_request(OP_TICK, 1'b1);
		send_request(OP_POLL, 1'b1);
		send_request(OP_UP, 1'b0);
		send_request(OP_DOWN, 1'b1);
		send_request(OP_SCAN, 1'b0);
		send_request(OP_EXIT, 1'b1);
		send_request(3'd7, 1'b1);
		// Enter twice: the second one is carried out again with its beep.
		send_request(OP_ENTER, 1'b0);
		send_request(OP_ENTER, 1'b1);
		// Manual steps wrap below the first and above the last channel.
		send_request(OP_DOWN, 1'b0);
		send_request(OP_UP, 1'b1);
		send_request(OP_SCAN, 1'b0);
		send_request(OP_TICK, 1'b0);
		// Four open polls confirm a hit and start the time dwell.
		repeat (4)
			send_request(OP_POLL, 1'b1);
		send_request(OP_TICK, 1'b0);
		send_request(OP_POLL, 1'b1);
		// Leaving the mode keeps the scan phase for the next enter.
		send_request(OP_EXIT, 1'b0);
		send_request(OP_POLL, 1'b0);
		send_request(OP_ENTER, 1'b0);
		send_request(OP_SCAN, 1'b1);
		send_request(3'd7, 1'b0);
		send_request(OP_TICK, 1'b1);
	endtask

	// Random traffic is built from bursts: runs of polls under a mostly steady
	// carrier so hits get confirmed, runs of ticks to drain the dwell (some of
	// them long enough for the largest dwell), single keys, mode changes and
	// a little noise that includes the unused operation code.
	task automatic run_random(input int unsigned budget);
		int unsigned goal;
		int unsigned pick;
		int unsigned len;
		logic        carrier;
		goal = counted_requests + budget;
		while (counted_requests < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				len     = $urandom_range(1, 8);
				carrier = 1'($urandom_range(0, 1));
				repeat (len)
					send_request(OP_POLL, ($urandom_range(0, 7) == 0) ? ~carrier : carrier);
			end else if (pick < 70) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) :
					$urandom_range(1, 6);
				repeat (len)
					send_request(OP_TICK, 1'($urandom_range(0, 1)));
			end else if (pick < 85) begin
				case ($urandom_range(0, 2))
					0:       send_request(OP_UP, 1'($urandom_range(0, 1)));
					1:       send_request(OP_DOWN, 1'($urandom_range(0, 1)));
					default: send_request(OP_SCAN, 1'($urandom_range(0, 1)));
				endcase
			end else if (pick < 92) begin
				send_request(OP_ENTER, 1'($urandom_range(0, 1)));
			end else if (pick < 95) begin
				send_request(OP_EXIT, 1'($urandom_range(0, 1)));
			end else begin
				send_request(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		logic [1:0]  mode_set [7];
		logic [7:0]  lost_set [7];
		logic [7:0]  find_set [7];
		int unsigned spin;
		// Register settings per phase, the unused scan mode and both ends
		// of the dwell range among them.
		mode_set = '{SM_CARRIER, SM_FIND, SM_TIME, 2'd3, SM_CARRIER, SM_FIND, SM_TIME};
		lost_set = '{8'd3, 8'd0, 8'd255, 8'd7, 8'd0, 8'd20, 8'd2};
		find_set = '{8'd5, 8'd255, 8'd0, 8'd2, 8'd0, 8'd1, 8'd9};
		sb               = new();
		counted_requests = 0;
		quiet_in         = 1'b0;
		quiet_out        = 1'b0;
		stall_left       = 0;
		arst_n           = 1'b0;
		in_valid         = 1'b0;
		operation        = OP_TICK;
		squelch_open     = 1'b0;
		out_stall        = 1'b0;
		cfg_valid        = 1'b0;
		cfg_index        = CFG_SCAN_MODE;
		cfg_data         = '0;
		repeat (10)
			@(negedge clk);
		arst_n = 1'b1;

		// The directed opening runs on the register reset values.
		run_directed();
		for (int p = 0; p < 7; p++) begin
			wait_drained();
			write_reg(CFG_SCAN_MODE, {6'd0, mode_set[p]});
			write_reg(CFG_LOST_DWELL, lost_set[p]);
			write_reg(CFG_FIND_DWELL, find_set[p]);
			run_random(PHASE_REQUESTS);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		spin = 0;
		while (sb.pending() != 0 && spin < 5000) begin
			@(posedge clk);
			spin++;
		end
		// A few more cycles catch any response the block sends unasked.
		repeat (8)
			@(posedge clk);
		sb.flag_leftovers();
		if (sb.err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
